// ===== rtl/htwd_pkg.sv =====
`timescale 1ns / 1ps

package htwd_pkg;

  localparam int MAX_NODES_DEF = 512;
  localparam int BITS_PER_BYTE = 8;
  localparam int IDX_W = 9;
  localparam int SYM_W = 9;

  localparam logic [SYM_W-1:0] EOS_SYMBOL = SYM_W'(256);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

endpackage

// ===== rtl/huffman_tree_walk_decoder_top.sv =====
`timescale 1ns / 1ps
// node load request: accepted while idle, table write lands at the edge that accepts it
// data byte: one node table read per bit, walked in ST_WALK, then ST_FLUSH releases
//   the last symbol; ready again once ST_FLUSH returns to ST_IDLE, so bytes never overlap
// the walk stalls on a new symbol while the output register is still held by the sink
// rst (synchronous, active high) returns the walk to the root and clears the
//   end-of-stream flag; the node table keeps its contents, undefined until written
module huffman_tree_walk_decoder_top
  import htwd_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // node_index[8:0], node_is_leaf[9], node_symbol[18:10], left_child[27:19],
  // right_child[36:28], data_byte[44:37], zero fill [47:45]
  input  logic [47:0] s_tdata,
  // func
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // symbol[7:0]
  output logic [7:0]  m_tdata,
  // stream_done
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  node_t               mem [MAX_NODES];
  node_t               rd_node;
  node_t               root;

  state_t              state, state_next;
  logic [AW-1:0]       cur, cur_next;
  logic [2:0]          bit_cnt, bit_cnt_next;
  logic [7:0]          byte_reg;
  logic                fin;
  logic                finished, finished_next;

  logic                pend_valid, pend_valid_next;
  logic [7:0]          pend_sym, pend_sym_next;
  logic                pend_done, pend_done_next;

  logic                m_tvalid_next;
  logic [7:0]          m_tdata_next;
  logic                m_tuser_next;
  logic                m_tlast_next;

  logic                in_req;
  logic                load_req;
  logic [IDX_W-1:0]    wr_idx;
  node_t               wr_node;
  logic                out_free;

  node_t               walk_node;
  logic [IDX_W-1:0]    child;
  logic                cur_bit;
  logic                emit;
  logic                eos;
  logic                stall;

  assign s_tready = (state == ST_IDLE);
  assign in_req   = s_tvalid && s_tready;
  assign load_req = in_req && (s_tuser == FUNC_LOAD);
  assign wr_idx   = s_tdata[8:0];
  assign wr_node  = '{leaf: s_tdata[9], sym: s_tdata[18:10],
                      left: s_tdata[27:19], right: s_tdata[36:28]};
  assign out_free = !m_tvalid || m_tready;

  // node step unit, used once per bit
  assign cur_bit   = byte_reg[bit_cnt];
  assign emit      = rd_node.leaf && ((rd_node.sym != EOS_SYMBOL) || fin);
  assign eos       = rd_node.leaf && (rd_node.sym == EOS_SYMBOL) && fin;
  assign walk_node = rd_node.leaf ? root : rd_node;
  assign child     = cur_bit ? walk_node.right : walk_node.left;
  assign stall     = emit && pend_valid && !out_free;

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    bit_cnt_next    = bit_cnt;
    finished_next   = finished;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    pend_done_next  = pend_done;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    m_tlast_next    = m_tlast;

    unique case (state)
      ST_IDLE: begin
        if (in_req && (s_tuser == FUNC_DATA) && !finished) begin
          state_next   = ST_WALK;
          bit_cnt_next = '0;
        end
      end
      ST_WALK: begin
        if (!stall) begin
          // a new symbol pushes the held one out, not yet the last of the run
          if (emit && pend_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = pend_sym;
            m_tuser_next  = pend_done;
            m_tlast_next  = 1'b0;
          end
          if (emit) begin
            pend_valid_next = 1'b1;
            pend_sym_next   = eos ? 8'd0 : rd_node.sym[7:0];
            pend_done_next  = eos;
          end
          if (eos) begin
            finished_next = 1'b1;
            cur_next      = '0;
            state_next    = ST_FLUSH;
          end else begin
            if (32'(child) < MAX_NODES) begin
              cur_next = AW'(child);
            end else begin
              cur_next = '0;
            end
            bit_cnt_next = bit_cnt + 3'd1;
            if (bit_cnt == 3'(BITS_PER_BYTE - 1)) begin
              state_next = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          m_tvalid_next   = 1'b1;
          m_tdata_next    = pend_sym;
          m_tuser_next    = pend_done;
          m_tlast_next    = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur        <= '0;
      bit_cnt    <= '0;
      finished   <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      bit_cnt    <= bit_cnt_next;
      finished   <= finished_next;
      pend_valid <= pend_valid_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_sym  <= pend_sym_next;
    pend_done <= pend_done_next;
    m_tdata   <= m_tdata_next;
    m_tuser   <= m_tuser_next;
    m_tlast   <= m_tlast_next;
    if (in_req && (s_tuser == FUNC_DATA)) begin
      byte_reg <= s_tdata[44:37];
      fin      <= s_tlast;
    end
  end

  // node table; the read port follows the next walk position so the node
  // under the walk is always in rd_node
  always_ff @(posedge clk) begin
    if (load_req && (32'(wr_idx) < MAX_NODES)) begin
      mem[AW'(wr_idx)] <= wr_node;
    end
    rd_node <= mem[cur_next];
  end

  // copy of the root, needed in the same cycle as the leaf node
  always_ff @(posedge clk) begin
    if (load_req && (wr_idx == '0)) begin
      root <= wr_node;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("symbol still held while ready for a request");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("end-of-stream result not marked last");

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("end-of-stream flag dropped without reset");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur) < MAX_NODES)
    else $error("walk position outside the node table");

  a_eos_returns_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && eos && !stall) |=> (cur == '0 && state == ST_FLUSH))
    else $error("end of stream did not return the walk to the root");

endmodule
